// File: hdl/assert_macros.svh
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled during reset.
`define AST_CHECK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: hdl/tmtc_pkg.sv
package tmtc_pkg;

  localparam int NUM_SAMPLES = 8;
  localparam int SORT_LAYERS = 6;
  localparam int MAX_PAIRS   = 4;
  localparam int GAIN_SHIFT  = 12;

  // config register widths
  localparam int GAIN_W = 17;
  localparam int TEMP_W = 15;

  typedef logic [2:0] lane_t;
  typedef logic [1:0] reg_idx_t;

  // register indexes, byte address is 4 * index
  localparam reg_idx_t REG_GAIN   = 2'd0;
  localparam reg_idx_t REG_OFFSET = 2'd1;
  localparam reg_idx_t REG_MIN    = 2'd2;
  localparam reg_idx_t REG_MAX    = 2'd3;

  // reset values
  localparam logic [GAIN_W-1:0]        GAIN_RST   = 17'd35245;
  localparam logic signed [TEMP_W-1:0] OFFSET_RST = 15'sd102;
  localparam logic [TEMP_W-1:0]        MIN_RST    = 15'd320;
  localparam logic [TEMP_W-1:0]        MAX_RST    = 15'd16000;

  // odd-even merge sort network for eight lanes, one row per layer
  localparam lane_t PAIR_LO [SORT_LAYERS][MAX_PAIRS] = '{
    '{3'd0, 3'd2, 3'd4, 3'd6},
    '{3'd0, 3'd1, 3'd4, 3'd5},
    '{3'd1, 3'd5, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd2, 3'd3, 3'd0, 3'd0},
    '{3'd1, 3'd3, 3'd5, 3'd0}
  };
  localparam lane_t PAIR_HI [SORT_LAYERS][MAX_PAIRS] = '{
    '{3'd1, 3'd3, 3'd5, 3'd7},
    '{3'd2, 3'd3, 3'd6, 3'd7},
    '{3'd2, 3'd6, 3'd0, 3'd0},
    '{3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd4, 3'd5, 3'd0, 3'd0},
    '{3'd2, 3'd4, 3'd6, 3'd0}
  };
  localparam lane_t PAIR_CNT [SORT_LAYERS] = '{
    3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd3
  };

endpackage

// File: hdl/tmtc_sort_layer.sv
// One layer of compare-exchange cells of the sorting network.
module tmtc_sort_layer #(
  parameter int SAMPLE_BITS = 12,
  parameter int LAYER       = 0
) (
  input  logic [tmtc_pkg::NUM_SAMPLES-1:0][SAMPLE_BITS-1:0] din,
  output logic [tmtc_pkg::NUM_SAMPLES-1:0][SAMPLE_BITS-1:0] dout
);

  // pairs inside a layer are disjoint, so every cell reads din directly
  always_comb begin
    tmtc_pkg::lane_t lo;
    tmtc_pkg::lane_t hi;
    dout = din;
    for (int p = 0; p < tmtc_pkg::MAX_PAIRS; p++) begin
      lo = tmtc_pkg::PAIR_LO[LAYER][p];
      hi = tmtc_pkg::PAIR_HI[LAYER][p];
      if (3'(p) < tmtc_pkg::PAIR_CNT[LAYER]) begin
        if (din[lo] > din[hi]) begin
          dout[lo] = din[hi];
          dout[hi] = din[lo];
        end
      end
    end
  end

endmodule

// File: hdl/trimmed_mean_temperature_convert.sv
// Trimmed-mean thermocouple temperature converter.
//
// Input stream: one request carries eight readings, sample_a in the lowest
// lane of in_tdata. Each request yields one result on the output stream:
// temperature (1/16 degC), trimmed mean (mV) and a clamp flag.
// Configuration goes through the APB-style cfg_ port: gain (Q5.12), offset,
// lower and upper clamp limits, at byte addresses 0, 4, 8 and 12.
//
// Six register stages: sort layers 1-2, 3-4, 5-6, middle sum, gain multiply,
// offset/clamp into the output register. One request is taken every cycle
// as long as out_tready does not stall the output.
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so a stall at out_tready fills bubbles first and only
// drops in_tready once all six stages hold a request. Nothing is lost or
// repeated across a stall.
// Reset (rst_n low, synchronous) empties the pipeline and returns the
// registers to gain 35245, offset 102, min 320, max 16000.
`include "assert_macros.svh"

module trimmed_mean_temperature_convert #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,

  // tdata: sample_a .. sample_h, SAMPLE_BITS each, from the lowest bit up
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  input  logic [tmtc_pkg::NUM_SAMPLES*SAMPLE_BITS-1:0]   in_tdata,

  // tdata: temperature[15], trimmed_mean_mv[SAMPLE_BITS], was_clamped[1],
  // zero padding to whole bytes, from the lowest bit up
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  output logic [((SAMPLE_BITS+16+7)/8)*8-1:0]            out_tdata,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NS     = tmtc_pkg::NUM_SAMPLES;
  localparam int NSTG   = 6;
  localparam int PROD_W = tmtc_pkg::GAIN_W + SAMPLE_BITS;
  localparam int SCL_W  = PROD_W - tmtc_pkg::GAIN_SHIFT;
  localparam int T_W    = SCL_W + 2;
  localparam int TW     = tmtc_pkg::TEMP_W;

  typedef logic [NS-1:0][SAMPLE_BITS-1:0] lanes_t;

  // configuration registers
  logic [tmtc_pkg::GAIN_W-1:0] gain_r;
  logic signed [TW-1:0]        offset_r;
  logic [TW-1:0]               min_r;
  logic [TW-1:0]               max_r;
  tmtc_pkg::reg_idx_t          cfg_idx;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= tmtc_pkg::GAIN_RST;
      offset_r <= tmtc_pkg::OFFSET_RST;
      min_r    <= tmtc_pkg::MIN_RST;
      max_r    <= tmtc_pkg::MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tmtc_pkg::REG_GAIN:   gain_r   <= cfg_pwdata[tmtc_pkg::GAIN_W-1:0];
        tmtc_pkg::REG_OFFSET: offset_r <= $signed(cfg_pwdata[TW-1:0]);
        tmtc_pkg::REG_MIN:    min_r    <= cfg_pwdata[TW-1:0];
        tmtc_pkg::REG_MAX:    max_r    <= cfg_pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      tmtc_pkg::REG_GAIN:   cfg_prdata = {{(32-tmtc_pkg::GAIN_W){1'b0}}, gain_r};
      tmtc_pkg::REG_OFFSET: cfg_prdata = {{(32-TW){offset_r[TW-1]}}, offset_r};
      tmtc_pkg::REG_MIN:    cfg_prdata = {{(32-TW){1'b0}}, min_r};
      tmtc_pkg::REG_MAX:    cfg_prdata = {{(32-TW){1'b0}}, max_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // stage flow control: a stage loads when empty or when its successor moves
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !valid_r[NSTG-1] || out_tready;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_comb begin
    valid_nxt = valid_r;
    if (rdy[0]) valid_nxt[0] = in_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) valid_nxt[k] = valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else        valid_r <= valid_nxt;
  end

  // sorting network, two layers per stage
  lanes_t lay_in  [tmtc_pkg::SORT_LAYERS];
  lanes_t lay_out [tmtc_pkg::SORT_LAYERS];
  lanes_t s1_r;
  lanes_t s2_r;
  lanes_t s3_r;

  assign lay_in[0] = in_tdata;
  assign lay_in[1] = lay_out[0];
  assign lay_in[2] = s1_r;
  assign lay_in[3] = lay_out[2];
  assign lay_in[4] = s2_r;
  assign lay_in[5] = lay_out[4];

  for (genvar g = 0; g < tmtc_pkg::SORT_LAYERS; g++) begin : g_layer
    tmtc_sort_layer #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LAYER       (g)
    ) u_layer (
      .din  (lay_in[g]),
      .dout (lay_out[g])
    );
  end

  // middle sum, gain product and clamp stages
  logic [SAMPLE_BITS+1:0] mid_sum;
  logic [SAMPLE_BITS-1:0] mean4_r;
  logic [SAMPLE_BITS-1:0] mean5_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SCL_W-1:0]       scaled;
  logic signed [T_W-1:0]  t_val;
  logic signed [T_W-1:0]  t_min;
  logic signed [T_W-1:0]  t_max;
  logic [TW-1:0]          temp_nxt;
  logic                   clamp_nxt;
  logic [TW-1:0]          temp_r;
  logic [SAMPLE_BITS-1:0] mean6_r;
  logic                   clamp_r;

  assign mid_sum = {2'b00, s3_r[2]} + {2'b00, s3_r[3]}
                 + {2'b00, s3_r[4]} + {2'b00, s3_r[5]};

  assign scaled = prod_r[PROD_W-1:tmtc_pkg::GAIN_SHIFT];
  assign t_val  = $signed({2'b00, scaled}) + T_W'(offset_r);
  assign t_min  = $signed({{(T_W-TW){1'b0}}, min_r});
  assign t_max  = $signed({{(T_W-TW){1'b0}}, max_r});

  // lower limit is tested first
  always_comb begin
    if (t_val < t_min) begin
      temp_nxt  = min_r;
      clamp_nxt = 1'b1;
    end else if (t_val > t_max) begin
      temp_nxt  = max_r;
      clamp_nxt = 1'b1;
    end else begin
      temp_nxt  = t_val[TW-1:0];
      clamp_nxt = 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (rdy[0] && in_tvalid) s1_r <= lay_out[1];
    if (rdy[1] && valid_r[0]) s2_r <= lay_out[3];
    if (rdy[2] && valid_r[1]) s3_r <= lay_out[5];
    if (rdy[3] && valid_r[2]) mean4_r <= mid_sum[SAMPLE_BITS+1:2];
    if (rdy[4] && valid_r[3]) begin
      prod_r  <= PROD_W'(gain_r) * PROD_W'(mean4_r);
      mean5_r <= mean4_r;
    end
    if (rdy[5] && valid_r[4]) begin
      temp_r  <= temp_nxt;
      mean6_r <= mean5_r;
      clamp_r <= clamp_nxt;
    end
  end

  // output packing
  assign out_tvalid = valid_r[NSTG-1];

  always_comb begin
    out_tdata = '0;
    out_tdata[TW-1:0]             = temp_r;
    out_tdata[TW +: SAMPLE_BITS]  = mean6_r;
    out_tdata[TW + SAMPLE_BITS]   = clamp_r;
  end

  // checks
  `AST_IMPLY(a_sorted_mid, clk, rst_n, valid_r[2],
             (s3_r[1] <= s3_r[2]) && (s3_r[2] <= s3_r[3]) &&
             (s3_r[3] <= s3_r[4]) && (s3_r[4] <= s3_r[5]) && (s3_r[5] <= s3_r[6]))
  `AST_IMPLY(a_full_on_stall, clk, rst_n, !in_tready, &valid_r)
  `AST_NEXT(a_bubble_in, clk, rst_n, in_tready && !in_tvalid, !valid_r[0])

endmodule
